### sv/efd_pkg.sv
// efd_pkg: shared types, constants and saturation helper for the explicit
// finite-difference option stencil; depends on nothing

package efd_pkg;

	localparam int MAX_NODES  = 4096;
	localparam int FRAC_BITS  = 32;
	localparam int Q_W        = 48;
	localparam int U_W        = 47;
	localparam int POS_W      = $clog2(MAX_NODES);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 48;
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int SW         = Q_W + 2;

	typedef logic signed [Q_W-1:0] q_t;
	typedef logic signed [SW-1:0] qw_t;

	localparam q_t QMAX  = {1'b0, {(Q_W-1){1'b1}}};
	localparam q_t QMIN  = {1'b1, {(Q_W-1){1'b0}}};
	localparam q_t Q_ONE = q_t'(64'd1 << FRAC_BITS);
	localparam qw_t WMAX = SW'(QMAX);
	localparam qw_t WMIN = SW'(QMIN);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNSTABLE = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_SHORT    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VARIANCE    = 3'd0,
		REG_CARRY       = 3'd1,
		REG_RATE        = 3'd2,
		REG_TIME_STEP   = 3'd3,
		REG_MIN_SPOT    = 3'd4,
		REG_SPACING     = 3'd5,
		REG_INV_SPACING = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [U_W-1:0] variance;
		q_t             carry;
		q_t             rate;
		logic [U_W-1:0] time_step;
		logic [U_W-1:0] min_spot;
		logic [U_W-1:0] spacing;
		logic [U_W-1:0] inv_spacing;
	} cfg_t;

	// one classified item for the back end
	typedef struct packed {
		logic             interior;
		logic [POS_W-1:0] idx;
		q_t               pl;
		q_t               pc;
		q_t               pu;
		q_t               bv;
		logic             tail;
		status_t          status;
	} cmd_t;

	typedef struct packed {
		q_t   val;
		logic ov;
	} sat_t;

	function automatic sat_t sat_wide(qw_t v);
		sat_t r;
		r.ov  = 1'b0;
		r.val = q_t'(v);
		if (v > WMAX) begin
			r.ov  = 1'b1;
			r.val = QMAX;
		end else if (v < WMIN) begin
			r.ov  = 1'b1;
			r.val = QMIN;
		end
		return r;
	endfunction

endpackage

### sv/efd_front.sv
// efd_front: accepts grid nodes, keeps the node position and value window,
// and classifies the items into commands; depends on efd_pkg

module efd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  efd_pkg::q_t          prev_value,
	input  efd_pkg::q_t          boundary_value,
	input  logic                 last_node,
	output logic                 cmd_push,
	output efd_pkg::cmd_t        cmd
);

	logic [efd_pkg::POS_W-1:0] pos_q;
	efd_pkg::q_t               win0_q, win1_q;
	logic                      last;
	logic                      early;

	assign last  = last_node | (pos_q == efd_pkg::POS_W'(efd_pkg::MAX_NODES - 1));
	assign early = pos_q < efd_pkg::POS_W'(2);

	always_comb begin
		cmd.interior = ~early;
		cmd.idx      = pos_q - efd_pkg::POS_W'(1);
		cmd.pl       = win0_q;
		cmd.pc       = win1_q;
		cmd.pu       = prev_value;
		cmd.bv       = boundary_value;
		cmd.tail     = last;
		cmd.status   = (early && last) ? efd_pkg::ST_SHORT : efd_pkg::ST_OK;
		cmd_push     = accept && (!early || last || pos_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			win0_q <= '0;
			win1_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
			end else begin
				pos_q  <= pos_q + efd_pkg::POS_W'(1);
				win0_q <= win1_q;
				win1_q <= prev_value;
			end
		end
	end

endmodule

### sv/efd_cmdq.sv
// efd_cmdq: short command queue between the front and back ends
// depends on efd_pkg

module efd_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_en,
	input  efd_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop_en,
	output logic          empty,
	output efd_pkg::cmd_t head
);

	efd_pkg::cmd_t               mem_q [efd_pkg::CMDQ_DEPTH];
	logic [efd_pkg::CMDQ_AW-1:0] wr_q, rd_q;
	logic [efd_pkg::CMDQ_AW:0]   cnt_q;
	logic                        do_push, do_pop;

	assign full    = cnt_q == (efd_pkg::CMDQ_AW+1)'(efd_pkg::CMDQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign head    = mem_q[rd_q];
	assign do_push = push_en && !full;
	assign do_pop  = pop_en && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + efd_pkg::CMDQ_AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + efd_pkg::CMDQ_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (efd_pkg::CMDQ_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (efd_pkg::CMDQ_AW+1)'(1);
			end
		end
	end

endmodule

### sv/efd_qmul.sv
// efd_qmul: fixed-point multiply with rounding and saturation, built from
// four half-width partial products; depends on efd_pkg

module efd_qmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  efd_pkg::q_t a,
	input  efd_pkg::q_t b,
	input  logic        extra,
	output logic        done,
	output efd_pkg::q_t res,
	output logic        ov
);

	localparam int HALF  = efd_pkg::Q_W / 2;
	localparam int ACC_W = 2 * efd_pkg::Q_W + 1;
	localparam logic [ACC_W-1:0] RND0 = ACC_W'(1) << (efd_pkg::FRAC_BITS - 1);
	localparam logic [ACC_W-1:0] RND1 = ACC_W'(1) << efd_pkg::FRAC_BITS;
	localparam logic [ACC_W-1:0] LIM  = ACC_W'(efd_pkg::QMAX);

	typedef enum logic [1:0] {M_IDLE, M_ACC, M_FIN} mstate_t;

	mstate_t                   state_q;
	logic [efd_pkg::Q_W-1:0]   xm_q, ym_q;
	logic                      neg_q, ext_q, done_q, ov_q;
	logic [1:0]                k_q;
	logic [ACC_W-1:0]          acc_q;
	efd_pkg::q_t               res_q;
	logic [efd_pkg::Q_W-1:0]   am, bm;
	logic [HALF-1:0]           xp, yp;
	logic [2*HALF-1:0]         prod;
	logic [1:0]                nhi;
	logic [ACC_W-1:0]          m, lim, msat;

	assign am   = a[efd_pkg::Q_W-1] ? efd_pkg::Q_W'(-a) : efd_pkg::Q_W'(a);
	assign bm   = b[efd_pkg::Q_W-1] ? efd_pkg::Q_W'(-b) : efd_pkg::Q_W'(b);
	assign xp   = k_q[1] ? xm_q[efd_pkg::Q_W-1:HALF] : xm_q[HALF-1:0];
	assign yp   = k_q[0] ? ym_q[efd_pkg::Q_W-1:HALF] : ym_q[HALF-1:0];
	assign prod = xp * yp;
	assign nhi  = {1'b0, k_q[1]} + {1'b0, k_q[0]};
	assign m    = ext_q ? (acc_q >> (efd_pkg::FRAC_BITS + 1)) : (acc_q >> efd_pkg::FRAC_BITS);
	assign lim  = neg_q ? LIM + ACC_W'(1) : LIM;
	assign msat = (m > lim) ? lim : m;

	assign done = done_q;
	assign res  = res_q;
	assign ov   = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			ov_q    <= 1'b0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				M_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						xm_q    <= am;
						ym_q    <= bm;
						neg_q   <= a[efd_pkg::Q_W-1] ^ b[efd_pkg::Q_W-1];
						ext_q   <= extra;
						acc_q   <= extra ? RND1 : RND0;
						k_q     <= '0;
						state_q <= M_ACC;
					end
				end
				M_ACC: begin
					acc_q <= acc_q + (ACC_W'(prod) << (HALF * nhi));
					k_q   <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= M_FIN;
					end
				end
				M_FIN: begin
					res_q   <= neg_q ? efd_pkg::q_t'(-msat) : efd_pkg::q_t'(msat);
					ov_q    <= m > lim;
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

endmodule

### sv/efd_back.sv
// efd_back: carries out classified commands, sequencing the stencil weights and
// sums through one shared multiplier into the result register; depends on efd_pkg, efd_qmul

module efd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  efd_pkg::cfg_t         cfg,
	input  efd_pkg::cmd_t         cmd,
	input  logic                  cmd_valid,
	output logic                  cmd_pop,
	input  logic                  out_pop,
	output logic                  out_valid,
	output logic [efd_pkg::U_W-1:0] next_value,
	output logic                  last_of_level,
	output logic [1:0]            status
);

	localparam int SU_W = efd_pkg::POS_W + efd_pkg::U_W + 1;
	localparam int SW   = efd_pkg::SW;
	localparam int LOW  = 24;

	typedef enum logic [3:0] {
		B_IDLE, B_SP0, B_SP1, B_SP2, B_MUL, B_WAIT, B_SUM, B_MI, B_EMIT, B_TAIL
	} bstate_t;

	typedef enum logic [3:0] {
		OP_X, OP_X2, OP_D, OP_C, OP_WL, OP_WU, OP_WM, OP_A1, OP_A2, OP_A3, OP_NX
	} op_t;

	bstate_t                 state_q;
	op_t                     op_q;
	efd_pkg::cmd_t           cmd_q;
	logic [SU_W-1:0]         plo_q, phi_q;
	efd_pkg::q_t             spot_q, x_q, t_q, d_q, c_q, lo_q, up_q, mi_q, acc_q, nx_q;
	logic                    ov_q, unst_q;
	logic                    out_valid_q, last_q;
	logic [efd_pkg::U_W-1:0] val_q;
	logic [1:0]              st_q;
	logic                    out_free;
	logic                    out_load;
	logic [SU_W-1:0]         su;
	efd_pkg::q_t             ma, mb;
	logic                    mext, mstart, mdone, mov;
	efd_pkg::q_t             mres;
	efd_pkg::sat_t           s_lo, s_up, s_nd, s_mi, s_wm, s_a2, s_a3, s_nx;
	logic                    wait_ov;
	efd_pkg::status_t        fin_st;

	function automatic logic [efd_pkg::U_W-1:0] clamp0(efd_pkg::q_t v);
		return v[efd_pkg::Q_W-1] ? '0 : v[efd_pkg::U_W-1:0];
	endfunction

	assign out_free      = !out_valid_q || out_pop;
	assign out_load      = (state_q == B_EMIT || state_q == B_TAIL) && out_free;
	assign cmd_pop       = (state_q == B_IDLE) && cmd_valid;
	assign mstart        = state_q == B_MUL;
	assign out_valid     = out_valid_q;
	assign next_value    = val_q;
	assign last_of_level = last_q;
	assign status        = st_q;

	assign su = SU_W'(cfg.min_spot) + plo_q + (phi_q << LOW);

	always_comb begin
		mext = 1'b0;
		unique case (op_q)
			OP_X:  begin ma = spot_q; mb = efd_pkg::q_t'({1'b0, cfg.inv_spacing}); end
			OP_X2: begin ma = x_q; mb = x_q; end
			OP_D:  begin ma = efd_pkg::q_t'({1'b0, cfg.variance}); mb = t_q; mext = 1'b1; end
			OP_C:  begin ma = cfg.carry; mb = x_q; mext = 1'b1; end
			OP_WL: begin ma = efd_pkg::q_t'({1'b0, cfg.time_step}); mb = lo_q; end
			OP_WU: begin ma = efd_pkg::q_t'({1'b0, cfg.time_step}); mb = up_q; end
			OP_WM: begin ma = efd_pkg::q_t'({1'b0, cfg.time_step}); mb = mi_q; end
			OP_A1: begin ma = lo_q; mb = cmd_q.pl; end
			OP_A2: begin ma = mi_q; mb = cmd_q.pc; end
			OP_A3: begin ma = up_q; mb = cmd_q.pu; end
			OP_NX: begin ma = efd_pkg::q_t'({1'b0, cfg.time_step}); mb = acc_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	efd_qmul u_qmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mstart),
		.a     (ma),
		.b     (mb),
		.extra (mext),
		.done  (mdone),
		.res   (mres),
		.ov    (mov)
	);

	always_comb begin
		s_lo = efd_pkg::sat_wide(SW'(d_q) - SW'(c_q));
		s_up = efd_pkg::sat_wide(SW'(d_q) + SW'(c_q));
		s_nd = efd_pkg::sat_wide(-(SW'(d_q) + SW'(d_q)));
		s_mi = efd_pkg::sat_wide(SW'(mi_q) - SW'(cfg.rate));
		s_wm = efd_pkg::sat_wide(SW'(efd_pkg::Q_ONE) + SW'(mres));
		s_a2 = efd_pkg::sat_wide(SW'(t_q) + SW'(mres));
		s_a3 = efd_pkg::sat_wide(SW'(acc_q) + SW'(mres));
		s_nx = efd_pkg::sat_wide(SW'(cmd_q.pc) + SW'(mres));
		case (op_q)
			OP_WM:   wait_ov = s_wm.ov;
			OP_A2:   wait_ov = s_a2.ov;
			OP_A3:   wait_ov = s_a3.ov;
			OP_NX:   wait_ov = s_nx.ov;
			default: wait_ov = 1'b0;
		endcase
		if (ov_q) begin
			fin_st = efd_pkg::ST_OVERFLOW;
		end else if (unst_q) begin
			fin_st = efd_pkg::ST_UNSTABLE;
		end else begin
			fin_st = efd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			op_q        <= OP_X;
			out_valid_q <= 1'b0;
			ov_q        <= 1'b0;
			unst_q      <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_pop);
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						ov_q    <= 1'b0;
						unst_q  <= 1'b0;
						op_q    <= OP_X;
						state_q <= cmd.interior ? B_SP0 : B_TAIL;
					end
				end
				B_SP0: begin
					plo_q   <= SU_W'(cmd_q.idx * cfg.spacing[LOW-1:0]);
					state_q <= B_SP1;
				end
				B_SP1: begin
					phi_q   <= SU_W'(cmd_q.idx * cfg.spacing[efd_pkg::U_W-1:LOW]);
					state_q <= B_SP2;
				end
				B_SP2: begin
					if (su > SU_W'(efd_pkg::QMAX)) begin
						ov_q   <= 1'b1;
						spot_q <= efd_pkg::QMAX;
					end else begin
						spot_q <= efd_pkg::q_t'(su);
					end
					state_q <= B_MUL;
				end
				B_MUL: begin
					state_q <= B_WAIT;
				end
				B_WAIT: begin
					if (mdone) begin
						ov_q <= ov_q | mov | wait_ov;
						case (op_q)
							OP_X: begin
								x_q     <= mres;
								op_q    <= OP_X2;
								state_q <= B_MUL;
							end
							OP_X2: begin
								t_q     <= mres;
								op_q    <= OP_D;
								state_q <= B_MUL;
							end
							OP_D: begin
								d_q     <= mres;
								op_q    <= OP_C;
								state_q <= B_MUL;
							end
							OP_C: begin
								c_q     <= mres;
								state_q <= B_SUM;
							end
							OP_WL: begin
								if (mres < 0) unst_q <= 1'b1;
								op_q    <= OP_WU;
								state_q <= B_MUL;
							end
							OP_WU: begin
								if (mres < 0) unst_q <= 1'b1;
								op_q    <= OP_WM;
								state_q <= B_MUL;
							end
							OP_WM: begin
								if (s_wm.val < 0) unst_q <= 1'b1;
								op_q    <= OP_A1;
								state_q <= B_MUL;
							end
							OP_A1: begin
								t_q     <= mres;
								op_q    <= OP_A2;
								state_q <= B_MUL;
							end
							OP_A2: begin
								acc_q   <= s_a2.val;
								op_q    <= OP_A3;
								state_q <= B_MUL;
							end
							OP_A3: begin
								acc_q   <= s_a3.val;
								op_q    <= OP_NX;
								state_q <= B_MUL;
							end
							default: begin
								nx_q    <= s_nx.val;
								state_q <= B_EMIT;
							end
						endcase
					end
				end
				B_SUM: begin
					lo_q <= s_lo.val;
					up_q <= s_up.val;
					mi_q <= s_nd.val;
					if (s_lo.ov || s_up.ov || s_nd.ov) begin
						ov_q <= 1'b1;
					end
					state_q <= B_MI;
				end
				B_MI: begin
					mi_q <= s_mi.val;
					if (s_mi.ov) begin
						ov_q <= 1'b1;
					end
					op_q    <= OP_WL;
					state_q <= B_MUL;
				end
				B_EMIT: begin
					if (out_free) begin
						val_q   <= clamp0(nx_q);
						last_q  <= 1'b0;
						st_q    <= fin_st;
						state_q <= cmd_q.tail ? B_TAIL : B_IDLE;
					end
				end
				B_TAIL: begin
					if (out_free) begin
						val_q   <= clamp0(cmd_q.bv);
						last_q  <= cmd_q.tail;
						st_q    <= cmd_q.status;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

### sv/explicit_fd_option_stencil.sv
// explicit_fd_option_stencil: top level of the explicit finite-difference stencil
// holds the configuration registers; depends on efd_pkg, efd_front, efd_cmdq, efd_back
//
// Nodes of one time level stream in through push/full and next-level values come
// out through empty/pop, oldest first. A boundary node bypasses the multiplier;
// the work of an interior node is set by the single shared multiplier, which
// forms each of the eleven products of the stencil in turn from four half-width
// partial products. When an interior node closes the level, the boundary value
// follows its result. A four-entry command queue lets the input side keep
// accepting nodes while the back end works and a result waits to be taken.
// Configuration writes are always taken and must only occur while the block is idle.

module explicit_fd_option_stencil (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [efd_pkg::Q_W-1:0]    prev_value,
	input  logic signed [efd_pkg::Q_W-1:0]    boundary_value,
	input  logic                              last_node,
	output logic                              empty,
	input  logic                              pop,
	output logic [efd_pkg::U_W-1:0]           next_value,
	output logic                              last_of_level,
	output logic [1:0]                        status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [efd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [efd_pkg::CFG_W-1:0]         cfg_data
);

	efd_pkg::cfg_t cfg_q;
	efd_pkg::cmd_t fe_cmd, q_head;
	logic          fe_push, q_empty, be_pop, out_valid, accept;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	assign empty     = !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.variance    <= '0;
			cfg_q.carry       <= '0;
			cfg_q.rate        <= '0;
			cfg_q.time_step   <= '0;
			cfg_q.min_spot    <= '0;
			cfg_q.spacing     <= efd_pkg::U_W'(64'd1 << efd_pkg::FRAC_BITS);
			cfg_q.inv_spacing <= efd_pkg::U_W'(64'd1 << efd_pkg::FRAC_BITS);
		end else if (cfg_valid) begin
			unique case (efd_pkg::reg_idx_t'(cfg_index))
				efd_pkg::REG_VARIANCE:    cfg_q.variance    <= cfg_data[efd_pkg::U_W-1:0];
				efd_pkg::REG_CARRY:       cfg_q.carry       <= cfg_data;
				efd_pkg::REG_RATE:        cfg_q.rate        <= cfg_data;
				efd_pkg::REG_TIME_STEP:   cfg_q.time_step   <= cfg_data[efd_pkg::U_W-1:0];
				efd_pkg::REG_MIN_SPOT:    cfg_q.min_spot    <= cfg_data[efd_pkg::U_W-1:0];
				efd_pkg::REG_SPACING:     cfg_q.spacing     <= cfg_data[efd_pkg::U_W-1:0];
				efd_pkg::REG_INV_SPACING: cfg_q.inv_spacing <= cfg_data[efd_pkg::U_W-1:0];
				default: ;
			endcase
		end
	end

	efd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.prev_value    (prev_value),
		.boundary_value(boundary_value),
		.last_node     (last_node),
		.cmd_push      (fe_push),
		.cmd           (fe_cmd)
	);

	efd_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (fe_push),
		.push_data(fe_cmd),
		.full     (full),
		.pop_en   (be_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	efd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (q_head),
		.cmd_valid    (!q_empty),
		.cmd_pop      (be_pop),
		.out_pop      (pop && out_valid),
		.out_valid    (out_valid),
		.next_value   (next_value),
		.last_of_level(last_of_level),
		.status       (status)
	);

endmodule

### test/tb_explicit_fd_option_stencil.sv
// tb_explicit_fd_option_stencil: self-checking testbench for the explicit fd stencil
// streams levels of grid nodes, predicts every next-level value and compares them
// depends on efd_pkg and explicit_fd_option_stencil
`timescale 1ns / 100ps

module tb_explicit_fd_option_stencil;

	localparam longint QM = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint QN = -QM - 1;
	localparam int LIMIT = 3000000;

	typedef struct {
		logic signed [47:0] pv;
		logic signed [47:0] bv;
		logic               last;
	} node_t;

	typedef struct {
		logic [46:0]       nv;
		logic              last;
		efd_pkg::status_t  st;
	} level_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [47:0] prev_value = '0;
	logic signed [47:0] boundary_value = '0;
	logic last_node = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [46:0] next_value;
	logic last_of_level;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [efd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [efd_pkg::CFG_W-1:0] cfg_data = '0;

	node_t node_q[$];
	level_out_t want_q[$];
	int errors = 0;
	int cycles = 0;
	int gap = 0;
	int stall = 0;
	bit took = 0;
	bit calm = 0;

	// predictor state
	longint m_var, m_carry, m_rate, m_dt, m_min, m_spc, m_inv;
	longint win_lo, win_hi;
	int node_pos;

	explicit_fd_option_stencil i_dut (.*);

	always #5 clk = ~clk;

	function automatic longint sat_q(longint v, inout bit ov);
		if (v > QM) begin
			ov = 1;
			return QM;
		end
		if (v < QN) begin
			ov = 1;
			return QN;
		end
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b, int extra, inout bit ov);
		bit neg;
		logic [127:0] p;
		longint lim;
		int s;
		neg = (a < 0) != (b < 0);
		s = efd_pkg::FRAC_BITS + extra;
		p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		p = (p + (128'd1 << (s - 1))) >> s;
		lim = neg ? QM + 1 : QM;
		if (p > 128'(lim)) begin
			ov = 1;
			p = 128'(lim);
		end
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic level_out_t mk_out(longint v, logic last, efd_pkg::status_t st);
		level_out_t o;
		o.nv = v < 0 ? '0 : v[46:0];
		o.last = last;
		o.st = st;
		return o;
	endfunction

	function automatic level_out_t stencil(int idx, longint pl, longint pc, longint pu);
		bit ov;
		longint su, x, x2, d, c, lo, mi, up, wl, wm, wu, acc, nx;
		efd_pkg::status_t st;
		ov = 0;
		st = efd_pkg::ST_OK;
		su = m_min + longint'(idx) * m_spc;
		if (su > QM) begin
			ov = 1;
			su = QM;
		end
		x = fx_mul(su, m_inv, 0, ov);
		x2 = fx_mul(x, x, 0, ov);
		d = fx_mul(m_var, x2, 1, ov);
		c = fx_mul(m_carry, x, 1, ov);
		lo = sat_q(d - c, ov);
		up = sat_q(d + c, ov);
		mi = sat_q(sat_q(-(d + d), ov) - m_rate, ov);
		wl = fx_mul(m_dt, lo, 0, ov);
		wu = fx_mul(m_dt, up, 0, ov);
		wm = sat_q((longint'(1) << efd_pkg::FRAC_BITS) + fx_mul(m_dt, mi, 0, ov), ov);
		acc = sat_q(fx_mul(lo, pl, 0, ov) + fx_mul(mi, pc, 0, ov), ov);
		acc = sat_q(acc + fx_mul(up, pu, 0, ov), ov);
		nx = sat_q(pc + fx_mul(m_dt, acc, 0, ov), ov);
		if (wl < 0 || wm < 0 || wu < 0)
			st = efd_pkg::ST_UNSTABLE;
		if (ov)
			st = efd_pkg::ST_OVERFLOW;
		return mk_out(nx, 1'b0, st);
	endfunction

	task automatic predict_node(longint pv, longint bv, logic lst);
		bit last;
		last = lst || node_pos >= efd_pkg::MAX_NODES - 1;
		if (node_pos < 2) begin
			if (last) begin
				want_q.push_back(mk_out(bv, 1'b1, efd_pkg::ST_SHORT));
				node_pos = 0;
				return;
			end
			if (node_pos == 0)
				want_q.push_back(mk_out(bv, 1'b0, efd_pkg::ST_OK));
		end else begin
			want_q.push_back(stencil(node_pos - 1, win_lo, win_hi, pv));
			if (last) begin
				want_q.push_back(mk_out(bv, 1'b1, efd_pkg::ST_OK));
				node_pos = 0;
				return;
			end
		end
		win_lo = win_hi;
		win_hi = pv;
		node_pos++;
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] exp_v);
		errors++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, exp_v, $realtime);
	endtask

	// input side and result side drivers
	always @(negedge clk) begin
		node_t n;
		if (!push || took) begin
			if (gap > 0) begin
				gap--;
				push <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(0, 9);
				push <= 1'b0;
			end else if (node_q.size() > 0) begin
				n = node_q.pop_front();
				push <= 1'b1;
				prev_value <= n.pv;
				boundary_value <= n.bv;
				last_node <= n.last;
			end else begin
				push <= 1'b0;
			end
		end
		if (stall > 0) begin
			stall--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall = $urandom_range(0, 9);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		level_out_t w;
		cycles++;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			took = push && !full;
			if (cfg_valid && cfg_ready) begin
				case (efd_pkg::reg_idx_t'(cfg_index))
					efd_pkg::REG_VARIANCE:    m_var = longint'(cfg_data[46:0]);
					efd_pkg::REG_CARRY:       m_carry = longint'(signed'(cfg_data[47:0]));
					efd_pkg::REG_RATE:        m_rate = longint'(signed'(cfg_data[47:0]));
					efd_pkg::REG_TIME_STEP:   m_dt = longint'(cfg_data[46:0]);
					efd_pkg::REG_MIN_SPOT:    m_min = longint'(cfg_data[46:0]);
					efd_pkg::REG_SPACING:     m_spc = longint'(cfg_data[46:0]);
					efd_pkg::REG_INV_SPACING: m_inv = longint'(cfg_data[46:0]);
					default: ;
				endcase
			end
			if (took)
				predict_node(longint'(prev_value), longint'(boundary_value), last_node);
			if (pop && !empty) begin
				if (want_q.size() == 0) begin
					report("unexpected item", 64'(next_value), 64'd0);
				end else begin
					w = want_q.pop_front();
					if (next_value !== w.nv)
						report("next_value", 64'(next_value), 64'(w.nv));
					if (last_of_level !== w.last)
						report("last_of_level", 64'(last_of_level), 64'(w.last));
					if (status !== w.st)
						report("status", 64'(status), 64'(w.st));
				end
			end
		end
	end

	function automatic logic [47:0] rnd48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	task automatic wait_idle();
		while (node_q.size() > 0 || push || want_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(efd_pkg::reg_idx_t idx, logic [47:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic write_all(logic [47:0] v[7]);
		for (int i = 0; i < 7; i++)
			write_reg(efd_pkg::reg_idx_t'(i), v[i]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_node(logic [47:0] pv, logic [47:0] bv, logic last);
		node_t n;
		n.pv = pv;
		n.bv = bv;
		n.last = last;
		node_q.push_back(n);
	endtask

	task automatic add_level(int n);
		logic [47:0] pv, bv;
		for (int i = 0; i < n; i++) begin
			pv = $urandom_range(0, 7) == 0 ? rnd48() : 48'({$urandom_range(0, 15), $urandom});
			bv = $urandom_range(0, 3) == 0 ? rnd48() : 48'($urandom);
			add_node(pv, bv, i == n - 1);
		end
	endtask

	task automatic fill_random(int count);
		int left, n;
		left = count;
		while (left > 0) begin
			n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 12);
			add_level(n);
			left -= n;
		end
	endtask

	task automatic random_regs(output logic [47:0] v[7]);
		for (int i = 0; i < 7; i++) begin
			if ($urandom_range(0, 2) == 0)
				v[i] = rnd48();
			else if (i == efd_pkg::REG_CARRY || i == efd_pkg::REG_RATE)
				v[i] = 48'(signed'(32'($urandom_range(0, 32'h1000_0000) - 32'h0800_0000)));
			else if (i == efd_pkg::REG_TIME_STEP)
				v[i] = 48'($urandom_range(0, 32'h0100_0000));
			else
				v[i] = 48'($urandom_range(1, 32'h4_0000_000));
			if (i != efd_pkg::REG_CARRY && i != efd_pkg::REG_RATE)
				v[i][47] = 1'b0;
			if ((i == efd_pkg::REG_SPACING || i == efd_pkg::REG_INV_SPACING) && v[i] == 0)
				v[i] = 48'd1;
		end
	endtask

	initial begin
		logic [47:0] regs[7];
		m_var = 0; m_carry = 0; m_rate = 0; m_dt = 0; m_min = 0;
		m_spc = longint'(1) << efd_pkg::FRAC_BITS;
		m_inv = longint'(1) << efd_pkg::FRAC_BITS;
		win_lo = 0; win_hi = 0; node_pos = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: short levels, extremes of the fields
		add_node(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b1);
		add_node(48'h0, 48'h8000_0000_0000, 1'b1);
		add_node(48'hFFFF_FFFF_FFFF, 48'h1234_5678_9ABC, 1'b0);
		add_node(48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
		add_node(48'h8000_0000_0000, 48'h0000_0001_0000, 1'b0);
		add_node(48'h7FFF_FFFF_FFFF, 48'h0, 1'b0);
		add_node(48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b1);
		add_node(48'h0000_0001_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
		add_node(48'h7FFF_FFFF_FFFF, 48'h0, 1'b0);
		add_node(48'h8000_0000_0000, 48'h0, 1'b0);
		add_node(48'h0, 48'h8000_0000_0000, 1'b1);
		wait_idle();

		// plausible market data
		regs = '{48'd171798692, 48'd214748365, 48'd128849019, 48'd4294967,
			48'd0, 48'h1_0000_0000, 48'h1_0000_0000};
		write_all(regs);
		fill_random(200);
		wait_idle();

		// largest weights
		regs = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
			48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF};
		write_all(regs);
		fill_random(30);
		wait_idle();

		// smallest weights
		regs = '{48'h0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0, 48'h0, 48'h1, 48'h1};
		write_all(regs);
		fill_random(30);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			random_regs(regs);
			write_all(regs);
			calm = (ph == 5);
			fill_random(190);
			wait_idle();
		end

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
